// File: rtl/core/polymul_pkg.sv
// Package for the polynomial multiplier: sizes, function codes and the
// packed transaction types of the input and result channels.
// No dependencies.
package polymul_pkg;

  // Capacity of each operand store
  localparam int MAX_TERMS = 16;
  localparam int IDX_W     = $clog2(MAX_TERMS);
  localparam int CNT_W     = IDX_W + 1;
  // Output index range is 0 .. 2*MAX_TERMS-2
  localparam int K_W       = $clog2(2 * MAX_TERMS);
  // Exact sum of MAX_TERMS Q32.32 products
  localparam int ACC_W     = 64 + IDX_W;
  localparam int RND_W     = ACC_W - 16;

  localparam logic [1:0] FUNC_LOAD_FIRST  = 2'd0;
  localparam logic [1:0] FUNC_LOAD_SECOND = 2'd1;
  localparam logic [1:0] FUNC_COMPUTE     = 2'd2;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] coefficient;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] product_coefficient;
    logic               saturated;
    logic               dropped_input;
    logic               last;
  } out_item_t;

endpackage

// File: rtl/core/polynomial_multiply_convolution.sv
// Polynomial multiplier by convolution: two 16-entry operand stores, one
// shared 32x32 multiplier and a wide accumulator. Uses polymul_pkg.
// Loads are taken only while idle. Per output coefficient, a compute sets
// up the overlap range, issues one term pair per cycle (up to 16), drains
// the pipeline, rounds and saturates, then skips a leading zero or outputs.
// Synchronous reset (rst_n low) empties both stores and clears the drop flag.
module polynomial_multiply_convolution
  import polymul_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TERM,
    ST_ISSUE,
    ST_DRAIN,
    ST_ROUND,
    ST_SAT,
    ST_WAIT_OUT
  } state_t;

  state_t state_r;

  // Operand stores
  logic signed [31:0] first_mem  [MAX_TERMS];
  logic signed [31:0] second_mem [MAX_TERMS];

  logic [CNT_W-1:0] first_count_r;
  logic [CNT_W-1:0] second_count_r;
  logic             dropped_r;

  // Sequencer registers
  logic [K_W-1:0]   k_r;
  logic [K_W-1:0]   len_r;
  logic [IDX_W-1:0] i_r;
  logic [IDX_W-1:0] i_hi_r;
  logic             started_r;

  // Datapath pipeline
  logic                    issue_v;
  logic                    rd_v_r;
  logic                    prod_v_r;
  logic signed [31:0]      first_rd_r;
  logic signed [31:0]      second_rd_r;
  logic signed [63:0]      prod_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_rnd;
  logic signed [RND_W-1:0] rnd_r;

  out_item_t out_data_r;
  logic      out_valid_r;

  logic [K_W-1:0]   j_full;
  logic [IDX_W-1:0] first_addr;
  logic [IDX_W-1:0] second_addr;
  logic [K_W-1:0]   i_lo_full;
  logic [K_W-1:0]   i_hi_full;
  logic [K_W-1:0]   k_nxt;
  logic             term_last;
  logic             ovf;
  logic [31:0]      sat_val;
  logic             load_first;
  logic             load_second;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign load_first  = in_valid && in_ready && (in_data.func == FUNC_LOAD_FIRST);
  assign load_second = in_valid && in_ready && (in_data.func == FUNC_LOAD_SECOND);

  // Term pair addresses: first[i] and second[k - i]
  assign j_full      = k_r - K_W'(i_r);
  assign first_addr  = i_r;
  assign second_addr = j_full[IDX_W-1:0];
  assign issue_v     = (state_r == ST_ISSUE);

  // Overlap range of term k
  assign i_lo_full = (k_r >= K_W'(second_count_r)) ?
                     (k_r - K_W'(second_count_r) + K_W'(1)) : '0;
  assign i_hi_full = (k_r < K_W'(first_count_r)) ?
                     k_r : (K_W'(first_count_r) - K_W'(1));

  assign k_nxt     = k_r + K_W'(1);
  assign term_last = (k_nxt == len_r);

  // Round half up, then saturate to 32 bits
  assign acc_rnd = acc_r + {{(ACC_W-16){1'b0}}, 16'h8000};
  assign ovf     = (rnd_r[RND_W-1:31] != '0) && (rnd_r[RND_W-1:31] != '1);
  assign sat_val = ovf ? (rnd_r[RND_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                       : rnd_r[31:0];

  // Store writes and registered reads
  always_ff @(posedge clk) begin
    if (load_first && (first_count_r < CNT_W'(MAX_TERMS))) begin
      first_mem[first_count_r[IDX_W-1:0]] <= in_data.coefficient;
    end
    if (load_second && (second_count_r < CNT_W'(MAX_TERMS))) begin
      second_mem[second_count_r[IDX_W-1:0]] <= in_data.coefficient;
    end
    first_rd_r  <= first_mem[first_addr];
    second_rd_r <= second_mem[second_addr];
  end

  // Shared multiplier and accumulator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r   <= 1'b0;
      prod_v_r <= 1'b0;
    end else begin
      rd_v_r   <= issue_v;
      prod_v_r <= rd_v_r;
    end
    prod_r <= first_rd_r * second_rd_r;
    if (state_r == ST_TERM) begin
      acc_r <= '0;
    end else if (prod_v_r) begin
      acc_r <= acc_r + {{IDX_W{prod_r[63]}}, prod_r};
    end
    rnd_r <= acc_rnd[ACC_W-1:16];
  end

  // Sequencer, counts and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      first_count_r  <= '0;
      second_count_r <= '0;
      dropped_r      <= 1'b0;
      out_valid_r    <= 1'b0;
      started_r      <= 1'b0;
      k_r            <= '0;
      len_r          <= '0;
      i_r            <= '0;
      i_hi_r         <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (load_first) begin
            if (first_count_r < CNT_W'(MAX_TERMS)) begin
              first_count_r <= first_count_r + CNT_W'(1);
            end else begin
              dropped_r <= 1'b1;
            end
          end
          if (load_second) begin
            if (second_count_r < CNT_W'(MAX_TERMS)) begin
              second_count_r <= second_count_r + CNT_W'(1);
            end else begin
              dropped_r <= 1'b1;
            end
          end
          if (in_valid && (in_data.func == FUNC_COMPUTE)) begin
            k_r       <= '0;
            started_r <= 1'b0;
            len_r     <= K_W'(first_count_r) + K_W'(second_count_r) - K_W'(1);
            if ((first_count_r == '0) || (second_count_r == '0)) begin
              // Empty operand: a single zero coefficient
              out_data_r.product_coefficient <= '0;
              out_data_r.saturated           <= 1'b0;
              out_data_r.dropped_input       <= dropped_r;
              out_data_r.last                <= 1'b1;
              out_valid_r                    <= 1'b1;
              state_r                        <= ST_WAIT_OUT;
            end else begin
              state_r <= ST_TERM;
            end
          end
        end

        ST_TERM: begin
          i_r     <= i_lo_full[IDX_W-1:0];
          i_hi_r  <= i_hi_full[IDX_W-1:0];
          state_r <= ST_ISSUE;
        end

        // One term pair per cycle into the multiplier
        ST_ISSUE: begin
          if (i_r == i_hi_r) begin
            state_r <= ST_DRAIN;
          end else begin
            i_r <= i_r + IDX_W'(1);
          end
        end

        ST_DRAIN: begin
          if (!rd_v_r && !prod_v_r) begin
            state_r <= ST_ROUND;
          end
        end

        ST_ROUND: begin
          state_r <= ST_SAT;
        end

        // Drop leading zeros, keep the final term
        ST_SAT: begin
          if (!started_r && !ovf && (rnd_r[31:0] == '0) && !term_last) begin
            k_r     <= k_nxt;
            state_r <= ST_TERM;
          end else begin
            started_r                      <= 1'b1;
            out_data_r.product_coefficient <= sat_val;
            out_data_r.saturated           <= ovf;
            out_data_r.dropped_input       <= dropped_r;
            out_data_r.last                <= term_last;
            out_valid_r                    <= 1'b1;
            state_r                        <= ST_WAIT_OUT;
          end
        end

        ST_WAIT_OUT: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            if (out_data_r.last) begin
              first_count_r  <= '0;
              second_count_r <= '0;
              dropped_r      <= 1'b0;
              state_r        <= ST_IDLE;
            end else begin
              k_r     <= k_nxt;
              state_r <= ST_TERM;
            end
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// Testbench for polynomial_multiply_convolution: drives load and compute
// transactions, predicts each product from its own operand stores and checks
// every streamed coefficient. Depends on polymul_pkg and the block's RTL.
module tb;
  import polymul_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int         CALM_ITEMS  = 40;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // Stimulus and expected product terms
  in_item_t  pending_items[$];
  out_item_t product_terms_due[$];
  int        total_items = 0;
  int        useful_items = 0;
  int        accepted_items = 0;
  int        mismatches = 0;
  int        feed_gap = 0;
  int        stall_left = 0;

  // Predictor state: operand stores, fill counts, refused-load flag
  logic signed [31:0] first_terms[MAX_TERMS];
  logic signed [31:0] second_terms[MAX_TERMS];
  int                 first_len = 0;
  int                 second_len = 0;
  bit                 drop_seen = 1'b0;

  polynomial_multiply_convolution dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one accepted transaction to the predictor state; queue the product
  task automatic predict_product(input in_item_t item);
    logic signed [71:0] acc;
    logic signed [71:0] rnd;
    logic signed [71:0] pa;
    logic signed [71:0] pb;
    out_item_t          term;
    int                 len;
    int                 k;
    int                 i;
    bit                 started;
    case (item.func)
      FUNC_LOAD_FIRST: begin
        if (first_len < MAX_TERMS) begin
          first_terms[first_len] = item.coefficient;
          first_len++;
        end else begin
          drop_seen = 1'b1;
        end
      end
      FUNC_LOAD_SECOND: begin
        if (second_len < MAX_TERMS) begin
          second_terms[second_len] = item.coefficient;
          second_len++;
        end else begin
          drop_seen = 1'b1;
        end
      end
      FUNC_COMPUTE: begin
        if (first_len == 0 || second_len == 0) begin
          term = '0;
          term.dropped_input = drop_seen;
          term.last = 1'b1;
          product_terms_due.push_back(term);
        end else begin
          len = first_len + second_len - 1;
          started = 1'b0;
          for (k = 0; k < len; k++) begin
            // Exact sum of Q32.32 products, then round half up to Q16.16
            acc = '0;
            for (i = 0; i < first_len; i++) begin
              if (k >= i && k - i < second_len) begin
                pa = first_terms[i];
                pb = second_terms[k - i];
                acc += pa * pb;
              end
            end
            rnd = (acc + 72'sd32768) >>> 16;
            term = '0;
            term.dropped_input = drop_seen;
            term.last = (k == len - 1);
            if (rnd > 72'sd2147483647) begin
              term.product_coefficient = 32'h7FFF_FFFF;
              term.saturated = 1'b1;
            end else if (rnd < -72'sd2147483648) begin
              term.product_coefficient = 32'h8000_0000;
              term.saturated = 1'b1;
            end else begin
              term.product_coefficient = rnd[31:0];
            end
            // Drop leading zero terms but always keep the last one
            if (started || term.product_coefficient != 0 || k == len - 1) begin
              started = 1'b1;
              product_terms_due.push_back(term);
            end
          end
        end
        first_len = 0;
        second_len = 0;
        drop_seen = 1'b0;
      end
      default: ;
    endcase
  endtask

  task automatic add_item(input logic [1:0] func, input logic [31:0] coefficient);
    in_item_t item;
    item.func = func;
    item.coefficient = coefficient;
    pending_items.push_back(item);
    if (func != FUNC_UNUSED)
      useful_items++;
  endtask

  function automatic logic [31:0] random_coefficient();
    logic signed [31:0] v;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5: v = $urandom();
      6, 7, 8, 9: begin
        v = $urandom_range(0, 16);
        v = (v - 32'sd8) <<< 16;
      end
      10, 11, 12, 13: begin
        v = $urandom_range(0, 32'h3FFFF);
        v = v - 32'sh20000;
      end
      14, 15, 16: v = '0;
      default: begin
        case ($urandom_range(0, 5))
          0: v = 32'h7FFF_FFFF;
          1: v = 32'h8000_0000;
          2: v = 32'h0000_8000;
          3: v = 32'hFFFF_8000;
          4: v = 32'h0000_0001;
          default: v = 32'hFFFF_FFFF;
        endcase
      end
    endcase
    return v;
  endfunction

  // Load two operands in random interleaving, then request the product
  task automatic add_product(input int n1, input int n2);
    int left1;
    int left2;
    int zlead;
    int pos1;
    left1 = n1;
    left2 = n2;
    pos1 = 0;
    zlead = (n1 > 0 && $urandom_range(0, 4) == 0) ? $urandom_range(1, n1) : 0;
    while (left1 > 0 || left2 > 0) begin
      if (left1 > 0 && (left2 == 0 || $urandom_range(0, 1) == 0)) begin
        add_item(FUNC_LOAD_FIRST, (pos1 < zlead) ? 32'h0 : random_coefficient());
        pos1++;
        left1--;
      end else begin
        add_item(FUNC_LOAD_SECOND, random_coefficient());
        left2--;
      end
    end
    add_item(FUNC_COMPUTE, $urandom());
  endtask

  function automatic int operand_size();
    return ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
  endfunction

  // Feed pending transactions; hold payload until accepted
  always @(posedge clk) begin : feed_proc
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (feed_gap > 0) begin
        feed_gap <= feed_gap - 1;
        in_valid <= 1'b0;
      end else if (accepted_items + CALM_ITEMS < total_items &&
                   $urandom_range(0, 7) == 0) begin
        feed_gap <= $urandom_range(0, 11);
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_data <= pending_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Stall the result channel in random bursts
  always @(posedge clk) begin : stall_proc
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (accepted_items + CALM_ITEMS < total_items &&
                 $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 11);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Predict on accepted inputs first, then check accepted results
  always @(posedge clk) begin : check_proc
    out_item_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_product(in_data);
        accepted_items++;
      end
      if (out_valid && out_ready) begin
        if (product_terms_due.size() == 0) begin
          $display("%0t: unexpected product term: got coef %h sat %b drop %b last %b",
                   $time, out_data.product_coefficient, out_data.saturated,
                   out_data.dropped_input, out_data.last);
          mismatches++;
        end else begin
          want = product_terms_due.pop_front();
          if (out_data !== want) begin
            $display("%0t: product term mismatch: expected coef %h sat %b drop %b last %b,",
                     $time, want.product_coefficient, want.saturated,
                     want.dropped_input, want.last,
                     " got coef %h sat %b drop %b last %b",
                     out_data.product_coefficient, out_data.saturated,
                     out_data.dropped_input, out_data.last);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin : main_proc
    int pick;
    // Empty operands and the unused code
    add_item(FUNC_COMPUTE, 32'h0);
    add_item(FUNC_UNUSED, 32'hFFFF_FFFF);
    add_item(FUNC_LOAD_FIRST, 32'h7FFF_FFFF);
    add_item(FUNC_COMPUTE, 32'hFFFF_FFFF);
    // Saturation toward both ends
    add_item(FUNC_LOAD_FIRST, 32'h8000_0000);
    add_item(FUNC_LOAD_SECOND, 32'h8000_0000);
    add_item(FUNC_COMPUTE, 32'h0);
    add_item(FUNC_LOAD_FIRST, 32'h7FFF_FFFF);
    add_item(FUNC_LOAD_SECOND, 32'h8000_0000);
    add_item(FUNC_COMPUTE, 32'h0);
    // Leading zeros skipped; all-zero product keeps its last term
    add_item(FUNC_LOAD_FIRST, 32'h0);
    add_item(FUNC_LOAD_FIRST, 32'h0);
    add_item(FUNC_LOAD_FIRST, 32'h0001_0000);
    add_item(FUNC_LOAD_SECOND, 32'h0001_0000);
    add_item(FUNC_COMPUTE, 32'h0);
    add_item(FUNC_LOAD_FIRST, 32'h0);
    add_item(FUNC_LOAD_SECOND, 32'h0);
    add_item(FUNC_LOAD_SECOND, 32'h0);
    add_item(FUNC_COMPUTE, 32'h0);
    // Rounding at exactly one half, positive and negative
    add_item(FUNC_LOAD_FIRST, 32'h0000_0001);
    add_item(FUNC_LOAD_SECOND, 32'h0000_8000);
    add_item(FUNC_COMPUTE, 32'h0);
    add_item(FUNC_LOAD_FIRST, 32'hFFFF_FFFF);
    add_item(FUNC_LOAD_SECOND, 32'h0000_8000);
    add_item(FUNC_COMPUTE, 32'h0);

    // Full stores with refused loads, then random products and noise
    add_product(MAX_TERMS + 1, MAX_TERMS);
    while (useful_items < 340) begin
      pick = $urandom_range(0, 99);
      if (pick < 5)
        add_item(FUNC_UNUSED, $urandom());
      else if (pick < 8)
        add_item(FUNC_COMPUTE, $urandom());
      else if (pick < 12)
        add_product(MAX_TERMS + $urandom_range(0, 2), $urandom_range(1, MAX_TERMS + 1));
      else
        add_product(operand_size(), operand_size());
    end
    total_items = pending_items.size();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every transaction and every product term, then drain
    do @(posedge clk);
    while (accepted_items < total_items || product_terms_due.size() > 0);
    repeat (64) @(posedge clk);
    if (mismatches == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

  initial begin : watchdog_proc
    #20_000_000;
    $display("tb: FAIL");
    $finish;
  end

endmodule
